// ===== sv/hbrp_pkg.sv =====
// Package for the HTTP byte-range header parser.
// Holds character constants, the unit prefix text and the stream payload widths.
// No dependencies.
package hbrp_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned NumW      = 32;
  localparam int unsigned PrefixLen = 6;
  localparam int unsigned PosW      = 3;

  // Result payload: has_start, has_end, range_start, range_end, padded to bytes.
  localparam int unsigned OutFieldW = 2 + 2 * NumW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam logic [CharW-1:0] CharDash  = 8'h2D;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;

  // Characters of the unit text "bytes=" by position.
  function automatic logic [CharW-1:0] prefix_char(input logic [PosW-1:0] pos);
    logic [CharW-1:0] c;
    unique case (pos)
      3'd0:    c = 8'h62;  // b
      3'd1:    c = 8'h79;  // y
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h73;  // s
      3'd5:    c = 8'h3D;  // =
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/http_byte_range_parser.sv =====
// Top level of the HTTP byte-range header parser.
// Depends on hbrp_pkg for character constants, prefix text and payload widths.
//
// The parser takes one character of a Range header value per transaction on the input
// stream, with in_tlast marking the last character, and returns one result transaction
// per value. The value must read "bytes=", optional start digits, a dash, optional end
// digits, then whitespace only; at least one number is required and end must not be
// below start when both are present. A number above 32 bits rejects the value.
// Throughput is one character per clock: each character is registered at the input,
// then a combinational update (prefix compare, multiply-by-ten-and-add of the digit
// accumulator, phase change) runs between that register and the parser state and
// result register. out_tvalid rises as the final character leaves the input register.
// Non-final characters keep flowing while a result waits on out_tready; a
// final character stalls only while the result register is occupied and not being
// taken. When out_tuser (status) is 1 the value was rejected and out_tdata is all zero.
module http_byte_range_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hbrp_pkg::CharW-1:0]       in_tdata,   // [7:0] char_code
  input  logic                             in_tlast,   // final_char
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hbrp_pkg::OutDataW-1:0]    out_tdata,  // [0] has_start, [1] has_end,
                                                       // [33:2] range_start,
                                                       // [65:34] range_end, rest zero
  output logic                             out_tuser   // status
);
  import hbrp_pkg::*;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_START,
    PH_END,
    PH_TAIL
  } phase_t;

  // Input register stage.
  logic             s1_valid_r, s1_valid_nxt;
  logic [CharW-1:0] s1_char_r;
  logic             s1_last_r;
  logic             s1_adv;

  // Parser state.
  phase_t          phase_r, phase_nxt;
  logic [PosW-1:0] prefix_pos_r, prefix_pos_nxt;
  logic [NumW-1:0] start_acc_r, start_acc_nxt;
  logic [NumW-1:0] end_acc_r, end_acc_nxt;
  logic            start_seen_r, start_seen_nxt;
  logic            end_seen_r, end_seen_nxt;
  logic            bad_r, bad_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  logic                out_status_r, out_status_nxt;

  // Character classes and digit accumulation.
  logic            is_digit, is_blank, is_dash;
  logic [CharW-1:0] digit_val;
  logic [NumW-1:0] acc_sel;
  logic [NumW+3:0] acc_prod;
  logic            acc_ovf;
  logic            ok;

  // A non-final character always proceeds; a final one needs room for its result.
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt = (in_tvalid && in_tready) || (s1_valid_r && !s1_adv);

  assign is_digit  = (s1_char_r >= CharZero) && (s1_char_r <= CharNine);
  assign is_blank  = (s1_char_r == CharSpace) ||
                     ((s1_char_r >= CharTab) && (s1_char_r <= CharCr));
  assign is_dash   = (s1_char_r == CharDash);
  assign digit_val = s1_char_r - CharZero;

  // acc * 10 + digit, as two shifted copies and the digit; overflow when the top is set.
  assign acc_sel  = (phase_r == PH_START) ? start_acc_r : end_acc_r;
  assign acc_prod = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} +
                    {{(NumW-4){1'b0}}, digit_val};
  assign acc_ovf  = |acc_prod[NumW+3:NumW];

  always_comb begin
    phase_nxt      = phase_r;
    prefix_pos_nxt = prefix_pos_r;
    start_acc_nxt  = start_acc_r;
    end_acc_nxt    = end_acc_r;
    start_seen_nxt = start_seen_r;
    end_seen_nxt   = end_seen_r;
    bad_nxt        = bad_r;
    ok             = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;

    if (s1_adv && !bad_r) begin
      unique case (phase_r)
        PH_PREFIX: begin
          if (s1_char_r == prefix_char(prefix_pos_r)) begin
            prefix_pos_nxt = prefix_pos_r + 1'b1;
            if (prefix_pos_r == PosW'(PrefixLen - 1)) begin
              phase_nxt = PH_START;
            end
          end else begin
            bad_nxt = 1'b1;
          end
        end
        PH_START: begin
          if (is_digit) begin
            if (acc_ovf) begin
              bad_nxt = 1'b1;
            end else begin
              start_acc_nxt = acc_prod[NumW-1:0];
            end
            start_seen_nxt = 1'b1;
          end else if (is_dash) begin
            phase_nxt = PH_END;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        PH_END: begin
          if (is_digit) begin
            if (acc_ovf) begin
              bad_nxt = 1'b1;
            end else begin
              end_acc_nxt = acc_prod[NumW-1:0];
            end
            end_seen_nxt = 1'b1;
          end else if (is_blank) begin
            phase_nxt = PH_TAIL;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        PH_TAIL: begin
          if (!is_blank) begin
            bad_nxt = 1'b1;
          end
        end
        default: bad_nxt = 1'b1;
      endcase
    end

    if (s1_adv && s1_last_r) begin
      ok = !bad_nxt && ((phase_nxt == PH_END) || (phase_nxt == PH_TAIL)) &&
           (start_seen_nxt || end_seen_nxt) &&
           !(start_seen_nxt && end_seen_nxt && (end_acc_nxt < start_acc_nxt));
      out_valid_nxt  = 1'b1;
      out_status_nxt = !ok;
      out_data_nxt   = '0;
      if (ok) begin
        out_data_nxt[0]             = start_seen_nxt;
        out_data_nxt[1]             = end_seen_nxt;
        out_data_nxt[NumW+1:2]      = start_seen_nxt ? start_acc_nxt : '0;
        out_data_nxt[2*NumW+1:NumW+2] = end_seen_nxt ? end_acc_nxt : '0;
      end
      // The next value starts from a clean parser.
      phase_nxt      = PH_PREFIX;
      prefix_pos_nxt = '0;
      start_acc_nxt  = '0;
      end_acc_nxt    = '0;
      start_seen_nxt = 1'b0;
      end_seen_nxt   = 1'b0;
      bad_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      phase_r      <= PH_PREFIX;
      prefix_pos_r <= '0;
      start_acc_r  <= '0;
      end_acc_r    <= '0;
      start_seen_r <= 1'b0;
      end_seen_r   <= 1'b0;
      bad_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      phase_r      <= phase_nxt;
      prefix_pos_r <= prefix_pos_nxt;
      start_acc_r  <= start_acc_nxt;
      end_acc_r    <= end_acc_nxt;
      start_seen_r <= start_seen_nxt;
      end_seen_r   <= end_seen_nxt;
      bad_r        <= bad_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // A rejected value carries no numbers.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("rejected result carries nonzero payload");

  // An accepted value names at least one number.
  a_accept_has_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[0] || out_tdata[1])
    else $error("accepted result without any number");

  // An accepted two-number range is never reversed.
  a_accept_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && out_tdata[0] && out_tdata[1] |->
      out_tdata[2*NumW+1:NumW+2] >= out_tdata[NumW+1:2])
    else $error("accepted range has end below start");

  // The final character of a value leaves the parser in its initial state.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> phase_r == PH_PREFIX && prefix_pos_r == '0 && !bad_r &&
      out_tvalid)
    else $error("parser did not restart after final character");

endmodule
